### sv/vtx4_pkg.sv
package vtx4_pkg;

  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LANES  = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    REG_ROW0_C01 = 4'd0,
    REG_ROW0_C23 = 4'd1,
    REG_ROW1_C01 = 4'd2,
    REG_ROW1_C23 = 4'd3,
    REG_ROW2_C01 = 4'd4,
    REG_ROW2_C23 = 4'd5,
    REG_ROW3_C01 = 4'd6,
    REG_ROW3_C23 = 4'd7
  } vtx4_reg_t;

  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic sat_en;
  } vtx4_adv_t;

endpackage

### sv/vtx4_lane.sv
module vtx4_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  vtx4_pkg::vtx4_adv_t adv,
  input  vtx4_pkg::word_t     coef [vtx4_pkg::LANES],
  input  vtx4_pkg::word_t     vec  [vtx4_pkg::LANES],
  output vtx4_pkg::word_t     res,
  output logic                clip
);
  import vtx4_pkg::*;

  localparam int RND_W = SUM_W - FRAC_BITS;
  localparam sum_t HALF = sum_t'(1) <<< (FRAC_BITS - 1);

  prod_t prod_r [LANES];
  pair_t pair_r [2];
  word_t res_r;
  logic  clip_r;

  sum_t              sum;
  logic [RND_W-1:0]  rnd;
  logic [RND_W-32:0] rnd_hi;
  word_t             res_nxt;
  logic              clip_nxt;

  // exact products
  always_ff @(posedge clk) begin
    if (adv.mul_en) begin
      for (int i = 0; i < LANES; i++) begin
        prod_r[i] <= coef[i] * vec[i];
      end
    end
  end

  // pair sums
  always_ff @(posedge clk) begin
    if (adv.add_en) begin
      pair_r[0] <= PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
      pair_r[1] <= PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
    end
  end

  // final sum, round half up, saturate
  always_comb begin
    sum    = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]) + HALF;
    rnd    = sum[SUM_W-1:FRAC_BITS];
    rnd_hi = rnd[RND_W-1:31];
    if ((&rnd_hi) || !(|rnd_hi)) begin
      res_nxt  = rnd[31:0];
      clip_nxt = 1'b0;
    end else begin
      res_nxt  = rnd[RND_W-1] ? WORD_MIN : WORD_MAX;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sat_en) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign res  = res_r;
  assign clip = clip_r;

endmodule

### sv/vtx4_merge.sv
module vtx4_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            lane_valid,
  input  vtx4_pkg::word_t lane_res  [vtx4_pkg::LANES],
  input  logic            lane_clip [vtx4_pkg::LANES],
  output logic            take,
  output logic            out_valid,
  input  logic            out_stall,
  output vtx4_pkg::word_t out_x,
  output vtx4_pkg::word_t out_y,
  output vtx4_pkg::word_t out_z,
  output vtx4_pkg::word_t out_w,
  output logic            out_clipped
);
  import vtx4_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  word_t x_r, y_r, z_r, w_r;
  logic  clip_r;

  assign take = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r    <= lane_res[0];
      y_r    <= lane_res[1];
      z_r    <= lane_res[2];
      w_r    <= lane_res[3];
      clip_r <= lane_clip[0] | lane_clip[1] | lane_clip[2] | lane_clip[3];
    end
  end

  assign out_valid   = valid_r;
  assign out_x       = x_r;
  assign out_y       = y_r;
  assign out_z       = z_r;
  assign out_w       = w_r;
  assign out_clipped = clip_r;

endmodule

### sv/vertex_transform_4x4_unit.sv
// channel | direction | payload                         | handshake
// in      | input     | in_x, in_y, in_z, in_w          | in_valid / in_stall
// out     | output    | out_x .. out_w, out_clipped     | out_valid / out_stall
// cfg     | input     | cfg_index, cfg_data             | cfg_we
//
// one request per cycle sustained while out_stall is low; from accept to out_valid a request
// passes these registers in order (products, pair sums, round and saturate, output register)
// synchronous active-low reset loads the identity matrix and empties the pipeline
// each stage holds on a stall only when the stage after it is full, so bubbles collapse
module vertex_transform_4x4_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vtx4_pkg::word_t in_x,
  input  vtx4_pkg::word_t in_y,
  input  vtx4_pkg::word_t in_z,
  input  vtx4_pkg::word_t in_w,
  output logic            out_valid,
  input  logic            out_stall,
  output vtx4_pkg::word_t out_x,
  output vtx4_pkg::word_t out_y,
  output vtx4_pkg::word_t out_z,
  output vtx4_pkg::word_t out_w,
  output logic            out_clipped,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_index,
  input  logic [63:0]     cfg_data
);
  import vtx4_pkg::*;

  localparam word_t ONE_Q = word_t'(1) <<< FRAC_BITS;

  word_t     mat_r [LANES][LANES];
  word_t     vec   [LANES];
  word_t     lane_res  [LANES];
  logic      lane_clip [LANES];
  logic      v1_r, v2_r, v3_r;
  logic      v1_nxt, v2_nxt, v3_nxt;
  logic      ready1, ready2, ready3, take;
  vtx4_adv_t adv;
  logic      wr_hit;
  logic [1:0] wr_row;
  logic      wr_upper;

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  // register decode
  always_comb begin
    wr_hit   = 1'b1;
    wr_row   = 2'd0;
    wr_upper = 1'b0;
    unique case (vtx4_reg_t'(cfg_index))
      REG_ROW0_C01: begin wr_row = 2'd0; wr_upper = 1'b0; end
      REG_ROW0_C23: begin wr_row = 2'd0; wr_upper = 1'b1; end
      REG_ROW1_C01: begin wr_row = 2'd1; wr_upper = 1'b0; end
      REG_ROW1_C23: begin wr_row = 2'd1; wr_upper = 1'b1; end
      REG_ROW2_C01: begin wr_row = 2'd2; wr_upper = 1'b0; end
      REG_ROW2_C23: begin wr_row = 2'd2; wr_upper = 1'b1; end
      REG_ROW3_C01: begin wr_row = 2'd3; wr_upper = 1'b0; end
      REG_ROW3_C23: begin wr_row = 2'd3; wr_upper = 1'b1; end
      default:      wr_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < LANES; r++) begin
        for (int c = 0; c < LANES; c++) begin
          mat_r[r][c] <= (r == c) ? ONE_Q : '0;
        end
      end
    end else if (cfg_we && wr_hit) begin
      if (wr_upper) begin
        mat_r[wr_row][2] <= cfg_data[63:32];
        mat_r[wr_row][3] <= cfg_data[31:0];
      end else begin
        mat_r[wr_row][0] <= cfg_data[63:32];
        mat_r[wr_row][1] <= cfg_data[31:0];
      end
    end
  end

  // pipeline control
  assign ready3   = !v3_r || take;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  assign adv.mul_en = ready1;
  assign adv.add_en = ready2;
  assign adv.sat_en = ready3;

  always_comb begin
    v1_nxt = ready1 ? in_valid : v1_r;
    v2_nxt = ready2 ? v1_r : v2_r;
    v3_nxt = ready3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    vtx4_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .adv  (adv),
      .coef (mat_r[g]),
      .vec  (vec),
      .res  (lane_res[g]),
      .clip (lane_clip[g])
    );
  end

  vtx4_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (v3_r),
    .lane_res   (lane_res),
    .lane_clip  (lane_clip),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .out_clipped(out_clipped)
  );

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !v1_r && !v2_r && !v3_r)
    else $error("pipeline not empty after reset");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v3_r))
    else $error("result without a request in the last stage");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_x == WORD_MAX || out_x == WORD_MIN || out_y == WORD_MAX || out_y == WORD_MIN ||
      out_z == WORD_MAX || out_z == WORD_MIN || out_w == WORD_MAX || out_w == WORD_MIN)
    else $error("clip flag without a saturated component");

  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !in_stall |=> v2_r)
    else $error("request lost between product and pair stages");

endmodule
